FILE: src/ring_fifo_with_search_top_defines.svh
`ifndef RING_FIFO_WITH_SEARCH_TOP_DEFINES_SVH
`define RING_FIFO_WITH_SEARCH_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define RFS_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RFS_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/rfs_pkg.sv
`default_nettype none

package rfs_pkg;

	localparam int unsigned CNT_W  = 5;
	localparam int unsigned POS_W  = 4;
	localparam int unsigned WORD_W = 32;
	localparam int unsigned OP_W   = 3;

	localparam logic [OP_W-1:0] OP_ENQUEUE = 3'd0;
	localparam logic [OP_W-1:0] OP_DEQUEUE = 3'd1;
	localparam logic [OP_W-1:0] OP_PEEK    = 3'd2;
	localparam logic [OP_W-1:0] OP_CLEAR   = 3'd3;
	localparam logic [OP_W-1:0] OP_SEARCH  = 3'd4;

	typedef struct packed {
		logic [OP_W-1:0]          operation;
		logic signed [WORD_W-1:0] value;
	} in_item_t;

	typedef struct packed {
		logic                     ok;
		logic signed [WORD_W-1:0] data_out;
		logic [POS_W-1:0]         match_position;
		logic [CNT_W-1:0]         count;
		logic                     is_empty;
		logic                     is_full;
	} out_item_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic shift;    // dequeue: each cell takes its upper neighbor's word, the last keeps its own
		logic write;    // enqueue: the cell at the tail position loads the value
		logic capture;  // search start: each cell latches its compare result
		logic scan;     // search step: hit flags move one cell toward the front
	} cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/ring_fifo_with_search_top.sv
// channel | dir | handshake            | beat
// in      | in  | in_valid / in_ready   | in_item   (operation, value)
// out     | out | out_valid / out_ready | out_item  (ok, data_out, match_position,
//         |     |                       |            count, is_empty, is_full)
// cfg     | in  | cfg_valid / cfg_ready | cfg_data  (capacity)
//
// Enqueue, dequeue, peek and clear finish as the beat is taken; the result is registered
// in the output register and the next beat is taken in the same cycle it leaves.
// Search scans from the front until the first match or the last entry (an empty
// queue answers like the other operations); the hit flags step down the cell chain one cell per cycle.
// After reset the queue is empty and capacity is 16 (or DEPTH if smaller);
// the cells are not cleared. A stalled output holds new beats off the input.
`default_nettype none

`include "ring_fifo_with_search_top_defines.svh"

module ring_fifo_with_search_top import rfs_pkg::*; #(
	parameter int unsigned DEPTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire in_item_t         in_item,
	output logic                  out_valid,
	input  wire logic             out_ready,
	output out_item_t             out_item,
	input  wire logic             cfg_valid,
	output logic                  cfg_ready,
	input  wire logic [CNT_W-1:0] cfg_data
);

	// capacity register is 5 bits, so no more than 31 cells are ever reachable
	localparam int unsigned CELLS = (DEPTH < 31) ? DEPTH : 31;
	localparam logic [CNT_W-1:0] CAP_LIM = CNT_W'(CELLS);
	localparam logic [CNT_W-1:0] CAP_RST = CNT_W'((CELLS < 16) ? CELLS : 16);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] cap_q;
	logic [CNT_W-1:0] scan_q;
	logic             out_valid_q;
	out_item_t        out_q;

	logic             in_fire;
	logic [CNT_W-1:0] cap_d;
	logic [CNT_W-1:0] count_d;
	out_item_t        res_d;
	logic             res_load;
	logic             scan_start;
	logic             scan_done;
	cell_ctrl_t       cell_ctrl;

	logic signed [WORD_W-1:0] cell_data [CELLS];
	logic signed [WORD_W-1:0] nxt_data  [CELLS];
	logic [CELLS-1:0]         cell_hit;
	logic [CELLS-1:0]         nxt_hit;

	for (genvar i = 0; i < CELLS; i++) begin : g_cell
		if (i == CELLS - 1) begin : g_last
			assign nxt_data[i] = cell_data[i];
			assign nxt_hit[i]  = 1'b0;
		end else begin : g_mid
			assign nxt_data[i] = cell_data[i+1];
			assign nxt_hit[i]  = cell_hit[i+1];
		end
		rfs_cell #(
			.IDX(i)
		) u_cell (
			.clk       (clk),
			.ctrl      (cell_ctrl),
			.tail      (count_q),
			.value     (in_item.value),
			.next_data (nxt_data[i]),
			.next_hit  (nxt_hit[i]),
			.data      (cell_data[i]),
			.hit       (cell_hit[i])
		);
	end

	assign in_fire   = in_valid && in_ready;
	assign in_ready  = (state_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// out-of-range capacity folds into 1..CELLS
	always_comb begin
		if (cfg_data == '0) begin
			cap_d = CNT_W'(1);
		end else if (cfg_data > CAP_LIM) begin
			cap_d = CAP_LIM;
		end else begin
			cap_d = cfg_data;
		end
	end

	always_comb begin
		cell_ctrl  = '0;
		count_d    = count_q;
		res_load   = 1'b0;
		scan_start = 1'b0;
		scan_done  = 1'b0;
		res_d      = '0;
		if (state_q == ST_IDLE) begin
			if (in_fire) begin
				res_load = 1'b1;
				case (in_item.operation)
					OP_ENQUEUE: begin
						if (count_q < cap_q) begin
							cell_ctrl.write = 1'b1;
							count_d         = count_q + CNT_W'(1);
							res_d.ok        = 1'b1;
						end
					end
					OP_DEQUEUE: begin
						if (count_q != '0) begin
							cell_ctrl.shift = 1'b1;
							count_d         = count_q - CNT_W'(1);
							res_d.ok        = 1'b1;
							res_d.data_out  = cell_data[0];
						end
					end
					OP_PEEK: begin
						if (count_q != '0) begin
							res_d.ok       = 1'b1;
							res_d.data_out = cell_data[0];
						end
					end
					OP_CLEAR: begin
						count_d  = '0;
						res_d.ok = 1'b1;
					end
					OP_SEARCH: begin
						cell_ctrl.capture = 1'b1;
						if (count_q != '0) begin
							res_load   = 1'b0;
							scan_start = 1'b1;
						end
					end
					default: begin
					end
				endcase
			end
		end else begin
			// front cell's hit flag now belongs to entry scan_q
			if (cell_hit[0]) begin
				res_load             = 1'b1;
				scan_done            = 1'b1;
				res_d.ok             = 1'b1;
				res_d.match_position = scan_q[POS_W-1:0];
			end else if (CNT_W'(scan_q + CNT_W'(1)) == count_q) begin
				res_load  = 1'b1;
				scan_done = 1'b1;
			end else begin
				cell_ctrl.scan = 1'b1;
			end
		end
		res_d.count    = count_d;
		res_d.is_empty = (count_d == '0);
		res_d.is_full  = (count_d == cap_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			cap_q       <= CAP_RST;
			scan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid) begin
				cap_q   <= cap_d;
				count_q <= '0;
			end else begin
				count_q <= count_d;
			end
			case (state_q)
				ST_IDLE: begin
					if (scan_start) begin
						state_q <= ST_SCAN;
						scan_q  <= '0;
					end
				end
				ST_SCAN: begin
					if (scan_done) begin
						state_q <= ST_IDLE;
					end else begin
						scan_q <= scan_q + CNT_W'(1);
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q <= res_d;
		end
	end

	`RFS_ASSERT_IMP(a_count_in_cap, 1'b1, count_q <= cap_q, "count above capacity")
	`RFS_ASSERT_IMP(a_no_accept_scan, state_q == ST_SCAN, !in_ready, "input taken during search")
	`RFS_ASSERT_IMP(a_scan_in_range, state_q == ST_SCAN, scan_q < count_q, "search ran past tail")
	`RFS_ASSERT_NXT(a_search_scans, in_fire && (in_item.operation == OP_SEARCH) && (count_q != '0) && !cfg_valid, state_q == ST_SCAN && !out_valid_q, "search did not start scan")

endmodule

`default_nettype wire

FILE: src/rfs_cell.sv
`default_nettype none

module rfs_cell import rfs_pkg::*; #(
	parameter int unsigned IDX = 0
) (
	input  wire logic                     clk,
	input  wire cell_ctrl_t               ctrl,
	input  wire logic [CNT_W-1:0]         tail,
	input  wire logic signed [WORD_W-1:0] value,
	input  wire logic signed [WORD_W-1:0] next_data,
	input  wire logic                     next_hit,
	output logic signed [WORD_W-1:0]      data,
	output logic                          hit
);

	logic signed [WORD_W-1:0] data_q;
	logic                     hit_q;

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			data_q <= next_data;
		end else if (ctrl.write && (tail == CNT_W'(IDX))) begin
			data_q <= value;
		end
		if (ctrl.capture) begin
			hit_q <= (data_q == value);
		end else if (ctrl.scan) begin
			hit_q <= next_hit;
		end
	end

	assign data = data_q;
	assign hit  = hit_q;

endmodule

`default_nettype wire

FILE: bench/ring_fifo_with_search_top_tb.sv
`default_nettype none

module ring_fifo_with_search_top_tb;
	import rfs_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned SLOTS = 16;
	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned LONG_HOLD_CYCLES = 150;
	localparam int unsigned TAIL_CYCLES = 40;

	localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_SEARCH + 1'b1;
	localparam logic [OP_W-1:0] OP_UNUSED_HI = '1;

	localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	in_item_t         in_item = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	out_item_t        out_item;
	logic             cfg_valid = 1'b0;
	logic             cfg_ready;
	logic [CNT_W-1:0] cfg_data = '0;

	ring_fifo_with_search_top #(
		.DEPTH(SLOTS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// queue contents as the block should hold them
	logic signed [WORD_W-1:0] ring_words [SLOTS];
	int unsigned              front_idx = 0;
	int unsigned              back_idx = 0;
	logic [CNT_W-1:0]         held = '0;
	logic [CNT_W-1:0]         cap_reg = CNT_W'(SLOTS);

	in_item_t                 op_backlog [$];
	out_item_t                expected_results [$];
	logic signed [WORD_W-1:0] recent_words [$];

	int unsigned send_idle_pct = 0;
	int unsigned recv_stall_pct = 0;
	logic        hold_request = 1'b0;
	logic        recv_blocked = 1'b0;
	int unsigned mismatches = 0;
	int unsigned cycle_count = 0;

	function automatic int unsigned wrap_next(input int unsigned idx, input int unsigned lim);
		return (idx + 1 >= lim) ? 0 : idx + 1;
	endfunction

	function automatic out_item_t fifo_apply(input in_item_t op);
		out_item_t   r;
		int unsigned lim;
		int unsigned idx;
		r = '0;
		lim = (cap_reg == 0) ? 1 : ((cap_reg > SLOTS) ? SLOTS : cap_reg);
		case (op.operation)
			OP_ENQUEUE: begin
				if (held < lim) begin
					ring_words[back_idx] = op.value;
					back_idx = wrap_next(back_idx, lim);
					held = held + 1'b1;
					r.ok = 1'b1;
				end
			end
			OP_DEQUEUE: begin
				if (held != 0) begin
					r.data_out = ring_words[front_idx];
					front_idx = wrap_next(front_idx, lim);
					held = held - 1'b1;
					r.ok = 1'b1;
				end
			end
			OP_PEEK: begin
				if (held != 0) begin
					r.data_out = ring_words[front_idx];
					r.ok = 1'b1;
				end
			end
			OP_CLEAR: begin
				front_idx = 0;
				back_idx = 0;
				held = '0;
				r.ok = 1'b1;
			end
			OP_SEARCH: begin
				// oldest equal entry wins
				idx = front_idx;
				for (int i = 0; i < held; i++) begin
					if (!r.ok && ring_words[idx] == op.value) begin
						r.ok = 1'b1;
						r.match_position = i[POS_W-1:0];
					end
					idx = wrap_next(idx, lim);
				end
			end
			default: ;
		endcase
		r.count = held;
		r.is_empty = (held == 0);
		r.is_full = (held == lim);
		return r;
	endfunction

	function automatic void compare_field(input string name, input logic [WORD_W-1:0] want_v,
			input logic [WORD_W-1:0] got_v);
		if (got_v !== want_v) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want_v, got_v);
			mismatches++;
		end
	endfunction

	// sender: one beat per accepted item, prediction taken at acceptance
	always @(posedge clk) begin : feed
		logic slot_free;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			slot_free = !in_valid || in_ready;
			if (in_valid && in_ready)
				expected_results.push_back(fifo_apply(in_item));
			if (slot_free) begin
				if (op_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					in_item <= op_backlog.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each result beat against the oldest prediction
	always @(posedge clk) begin : observe
		out_item_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual %p", $time, out_item);
					mismatches++;
				end else begin
					want = expected_results.pop_front();
					compare_field("ok", WORD_W'(want.ok), WORD_W'(out_item.ok));
					compare_field("data_out", want.data_out, out_item.data_out);
					compare_field("match_position", WORD_W'(want.match_position),
						WORD_W'(out_item.match_position));
					compare_field("count", WORD_W'(want.count), WORD_W'(out_item.count));
					compare_field("is_empty", WORD_W'(want.is_empty), WORD_W'(out_item.is_empty));
					compare_field("is_full", WORD_W'(want.is_full), WORD_W'(out_item.is_full));
				end
			end
			out_ready <= !recv_blocked && ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	// long receiver hold-off so the block backs up into its input
	always begin : long_hold
		while (!hold_request)
			@(posedge clk);
		recv_blocked <= 1'b1;
		repeat (LONG_HOLD_CYCLES) @(posedge clk);
		recv_blocked <= 1'b0;
		hold_request <= 1'b0;
		@(posedge clk);
	end

	always @(posedge clk) begin : watchdog
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	task automatic offer(input logic [OP_W-1:0] code, input logic signed [WORD_W-1:0] word);
		in_item_t op;
		op.operation = code;
		op.value = word;
		op_backlog.push_back(op);
	endtask

	// judged at the falling edge, once the rising-edge handshakes have settled
	task automatic wait_drained();
		do
			@(negedge clk);
		while (op_backlog.size() != 0 || in_valid || expected_results.size() != 0);
		@(posedge clk);
	endtask

	task automatic set_capacity(input logic [CNT_W-1:0] slots);
		cfg_data <= slots;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cfg_valid <= 1'b0;
		// a capacity write also empties the queue
		cap_reg = slots;
		front_idx = 0;
		back_idx = 0;
		held = '0;
	endtask

	function automatic logic signed [WORD_W-1:0] pick_word();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 30 && recent_words.size() != 0)
			return recent_words[$urandom_range(0, recent_words.size() - 1)];
		if (r < 45) begin
			case ($urandom_range(0, 3))
				0: return WORD_MIN;
				1: return WORD_MAX;
				2: return '0;
				default: return '1;
			endcase
		end
		return $urandom;
	endfunction

	task automatic offer_random_ops(input int unsigned n);
		int unsigned left;
		int unsigned burst;
		int unsigned mode;
		int unsigned r;
		int unsigned enq_lim;
		int unsigned deq_lim;
		logic signed [WORD_W-1:0] w;
		left = n;
		while (left != 0) begin
			burst = $urandom_range(8, 40);
			if (burst > left)
				burst = left;
			left -= burst;
			// fill, drain or mixed burst
			mode = $urandom_range(0, 2);
			enq_lim = (mode == 0) ? 70 : ((mode == 1) ? 18 : 40);
			deq_lim = (mode == 0) ? 75 : ((mode == 1) ? 63 : 68);
			repeat (burst) begin
				r = $urandom_range(0, 99);
				if (r < enq_lim) begin
					w = pick_word();
					offer(OP_ENQUEUE, w);
					recent_words.push_back(w);
					if (recent_words.size() > 12)
						void'(recent_words.pop_front());
				end else if (r < deq_lim) begin
					offer(OP_DEQUEUE, $urandom);
				end else if (r < 80) begin
					offer(OP_PEEK, $urandom);
				end else if (r < 96) begin
					if ($urandom_range(0, 99) < 65 && recent_words.size() != 0)
						w = recent_words[$urandom_range(0, recent_words.size() - 1)];
					else
						w = pick_word();
					offer(OP_SEARCH, w);
				end else if (r < 98) begin
					offer(OP_CLEAR, $urandom);
				end else begin
					offer(OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), $urandom);
				end
			end
		end
	endtask

	task automatic run_phase(input logic [CNT_W-1:0] slots, input int unsigned send_pct,
			input int unsigned recv_pct, input int unsigned n);
		wait_drained();
		set_capacity(slots);
		send_idle_pct <= send_pct;
		recv_stall_pct <= recv_pct;
		recent_words.delete();
		offer_random_ops(n);
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: extremes, every operation, refusals, unknown codes
		offer(OP_PEEK, '0);
		offer(OP_DEQUEUE, '0);
		offer(OP_SEARCH, '0);
		offer(OP_ENQUEUE, WORD_MIN);
		offer(OP_ENQUEUE, WORD_MAX);
		offer(OP_ENQUEUE, '0);
		offer(OP_ENQUEUE, '1);
		offer(OP_ENQUEUE, WORD_MAX);
		offer(OP_PEEK, '0);
		offer(OP_SEARCH, WORD_MAX);
		offer(OP_SEARCH, '1);
		offer(OP_SEARCH, 32'sd12345);
		offer(OP_UNUSED_LO, WORD_MAX);
		offer(OP_UNUSED_LO + 1'b1, '1);
		offer(OP_UNUSED_HI, WORD_MIN);
		offer(OP_DEQUEUE, '0);
		offer(OP_DEQUEUE, '0);
		offer(OP_CLEAR, '1);
		offer(OP_DEQUEUE, '0);
		wait_drained();
		set_capacity(CNT_W'(2));
		offer(OP_ENQUEUE, 32'sd7);
		offer(OP_ENQUEUE, -32'sd7);
		offer(OP_ENQUEUE, 32'sd9);
		offer(OP_SEARCH, -32'sd7);
		offer(OP_DEQUEUE, '0);
		offer(OP_ENQUEUE, 32'sd9);
		offer(OP_SEARCH, 32'sd9);

		run_phase(CNT_W'(SLOTS), 0, 0, 170);

		// sender keeps offering while the receiver holds off
		wait_drained();
		hold_request <= 1'b1;
		offer_random_ops(60);

		run_phase('0, 68, 0, 160);
		run_phase('1, 0, 68, 170);
		run_phase(CNT_W'(1), 25, 25, 120);
		run_phase(CNT_W'(SLOTS + 1), 0, 0, 160);
		run_phase(CNT_W'($urandom_range(2, SLOTS - 1)), 68, 0, 160);
		run_phase(CNT_W'(5), 0, 68, 150);
		run_phase(CNT_W'(SLOTS), 25, 25, 170);

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

`default_nettype wire

FILE: ring_fifo_with_search_top.f
+incdir+src
src/rfs_pkg.sv
src/rfs_cell.sv
src/ring_fifo_with_search_top.sv
bench/ring_fifo_with_search_top_tb.sv
